// File: hdl/lpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the LED palette color map
// Holds the palette codes, the pixel type and the fixed color tables.
// ----------------------------------------------------------------------------
package lpc_pkg;

	typedef enum logic [2:0] {
		PalRainbow   = 3'd0,
		PalWheel     = 3'd1,
		PalFlame     = 3'd2,
		PalCold      = 3'd3,
		PalWarm      = 3'd4,
		PalColdWhite = 3'd5,
		PalWarmWhite = 3'd6,
		PalBlack     = 3'd7
	} palette_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam int RainbowEntries = 7;
	localparam int RainbowStep    = 36;

	localparam logic [7:0] WheelSeg1  = 8'd85;
	localparam logic [7:0] WheelSeg2  = 8'd170;
	localparam logic [7:0] FlameScale = 8'd84;
	localparam logic [6:0] FlameFold  = 7'd42;
	localparam logic [6:0] FlameTop   = 7'd84;

	localparam rgb_t RainbowTab [RainbowEntries] = '{
		'{red: 8'hFF, green: 8'h00, blue: 8'h00},
		'{red: 8'hFF, green: 8'h7F, blue: 8'h00},
		'{red: 8'hFF, green: 8'hFF, blue: 8'h00},
		'{red: 8'h00, green: 8'hFF, blue: 8'h00},
		'{red: 8'h42, green: 8'hAA, blue: 8'hFF},
		'{red: 8'h00, green: 8'h00, blue: 8'hFF},
		'{red: 8'h8B, green: 8'h00, blue: 8'hFF}
	};

	localparam rgb_t ColdWhite = '{red: 8'hF0, green: 8'hF8, blue: 8'hFF};
	localparam rgb_t WarmWhite = '{red: 8'hFF, green: 8'hCF, blue: 8'h48};
	localparam rgb_t Black     = '{red: 8'h00, green: 8'h00, blue: 8'h00};

endpackage

// File: hdl/lpc_color_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_color_calc: palette lookup logic
// Turns one color index into a pixel under the selected palette.
// ----------------------------------------------------------------------------
module lpc_color_calc (
	input  lpc_pkg::palette_t palette,
	input  logic [7:0]        color_index,
	output lpc_pkg::rgb_t     color
);

	// Three-segment wheel: one channel falls by three per step while the next rises.
	function automatic lpc_pkg::rgb_t wheel(input logic [7:0] pos);
		logic [7:0] off;
		logic [7:0] rise;
		logic [7:0] fall;
		lpc_pkg::rgb_t c;
		begin
			if (pos < lpc_pkg::WheelSeg1) begin
				off = pos;
			end else if (pos < lpc_pkg::WheelSeg2) begin
				off = pos - lpc_pkg::WheelSeg1;
			end else begin
				off = pos - lpc_pkg::WheelSeg2;
			end
			rise = 8'({off, 1'b0} + {1'b0, off});
			fall = 8'hFF - rise;
			if (pos < lpc_pkg::WheelSeg1) begin
				c = '{red: fall, green: rise, blue: 8'h00};
			end else if (pos < lpc_pkg::WheelSeg2) begin
				c = '{red: 8'h00, green: fall, blue: rise};
			end else begin
				c = '{red: rise, green: 8'h00, blue: fall};
			end
			return c;
		end
	endfunction

	logic [2:0]  rainbow_k;
	logic [14:0] flame_prod;
	logic [15:0] flame_p1;
	logic [6:0]  flame_k;
	logic [7:0]  flame_pos;
	logic [6:0]  fold_i;
	logic [7:0]  fold_up;

	// Rainbow entry is the index over 36, with the top sliver held at violet.
	always_comb begin
		rainbow_k = 3'd0;
		for (int j = 1; j < lpc_pkg::RainbowEntries; j++) begin
			if (color_index >= 8'(j * lpc_pkg::RainbowStep)) begin
				rainbow_k = 3'(j);
			end
		end
	end

	// Flame position: index * 84 / 255, the division done as a reciprocal
	// shift with a correction, then folded into a triangle over 0 to 42.
	always_comb begin
		flame_prod = 15'(color_index) * 15'(lpc_pkg::FlameScale);
		flame_p1   = 16'(flame_prod) + 16'd1;
		flame_k    = 7'((flame_p1 + (flame_p1 >> 8)) >> 8);
		if (flame_k < lpc_pkg::FlameFold) begin
			flame_pos = 8'(flame_k);
		end else if (flame_k == lpc_pkg::FlameTop) begin
			flame_pos = 8'd0;
		end else begin
			flame_pos = 8'(lpc_pkg::FlameTop - flame_k);
		end
	end

	// The upper half of the index mirrors the lower half.
	always_comb begin
		fold_i  = color_index[7] ? ~color_index[6:0] : color_index[6:0];
		fold_up = {fold_i, 1'b0};
	end

	always_comb begin
		case (palette)
			lpc_pkg::PalRainbow:   color = lpc_pkg::RainbowTab[rainbow_k];
			lpc_pkg::PalWheel:     color = wheel(color_index);
			lpc_pkg::PalFlame:     color = wheel(flame_pos);
			lpc_pkg::PalCold:      color = '{red: 8'h00, green: ~fold_up, blue: fold_up};
			lpc_pkg::PalWarm:      color = '{red: ~fold_up, green: 8'h00, blue: fold_up};
			lpc_pkg::PalColdWhite: color = lpc_pkg::ColdWhite;
			lpc_pkg::PalWarmWhite: color = lpc_pkg::WarmWhite;
			default:               color = lpc_pkg::Black;
		endcase
	end

endmodule

// File: hdl/led_palette_color_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_palette_color_map: color index to RGB pixel
// Maps an 8-bit color index to a red, green and blue pixel under a palette
// chosen by one configuration register.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_ready | color_index[7:0]
//  output  | out_valid/out_ready | red_level, green_level, blue_level [7:0]
//  config  | cfg_we (no wait)    | cfg_wdata[2:0] = palette_select
//
//  Each transaction passes through the input register and then the result
//  register. One transaction is accepted per cycle when the output is
//  drained every cycle.
//  Under a stall both registers hold their transaction, so the pipe keeps two;
//  the input register moves on whenever the result register is empty or read.
//  Reset clears both valid flags and sets the palette to the color wheel.
//
module led_palette_color_map (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] color_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_level,
	output logic [7:0] green_level,
	output logic [7:0] blue_level
);

	lpc_pkg::palette_t palette_q;
	logic              valid_s1;
	logic [7:0]        index_s1;
	logic              valid_s2;
	lpc_pkg::rgb_t     rgb_s2;
	lpc_pkg::rgb_t     rgb_calc;
	logic              advance_s2;

	// The palette register. The user must let it change only while no transaction is in
	// flight; the block itself does not enforce this, so the lookup reads it directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= lpc_pkg::PalWheel;
		end else if (cfg_we) begin
			palette_q <= lpc_pkg::palette_t'(cfg_wdata);
		end
	end

	// The result register may load when it is empty or its pixel is taken now.
	assign advance_s2 = !valid_s2 || out_ready;
	// The input register may load when it is empty or it moves on this cycle.
	assign in_ready   = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			index_s1 <= color_index;
		end
	end

	lpc_color_calc u_calc (
		.palette     (palette_q),
		.color_index (index_s1),
		.color       (rgb_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			rgb_s2 <= rgb_calc;
		end
	end

	assign out_valid   = valid_s2;
	assign red_level   = rgb_s2.red;
	assign green_level = rgb_s2.green;
	assign blue_level  = rgb_s2.blue;

`ifndef SYNTHESIS
	// Back-pressure on the input only comes from a full pipe with a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a full, stalled pipeline");

	// An accepted transaction lands in the input register with its index.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1 && index_s1 == $past(color_index))
		else $error("accepted transaction not captured in the input register");

	// A transaction that leaves the input register appears at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance_s2 |=> valid_s2)
		else $error("transaction lost between input and result registers");

	// The black palette gives an all-zero pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance_s2 && palette_q == lpc_pkg::PalBlack
		|=> red_level == 8'h00 && green_level == 8'h00 && blue_level == 8'h00)
		else $error("black palette produced a lit pixel");
`endif

endmodule
